// File: rtl/pva_pkg.sv
package pva_pkg;

  typedef enum logic [1:0] {
    CMD_NOTE_ON   = 2'd0,
    CMD_NOTE_OFF  = 2'd1,
    CMD_ALL_OFF   = 2'd2,
    CMD_VOICE_DONE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic capture;
    logic scan_en;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic in_scan;
    logic scan_last;
  } stat_t;

endpackage

// File: rtl/pva_ctrl.sv
module pva_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  pva_pkg::stat_t  stat,
  output pva_pkg::ctrl_t  ctrl
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   finish;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (state == S_FINISH) && (!out_valid || out_ready);

  assign ctrl.capture = accept;
  assign ctrl.scan_en = (state == S_SCAN);
  assign ctrl.finish  = finish;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = stat.in_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/pva_datapath.sv
module pva_datapath #(
  parameter int NUM_VOICES = 16,
  parameter int AGE_BITS   = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  pva_pkg::ctrl_t  ctrl,
  output pva_pkg::stat_t  stat,
  input  logic [1:0]      command,
  input  logic [6:0]      note,
  input  logic [6:0]      velocity,
  input  logic [3:0]      voice_select,
  output logic            started,
  output logic [3:0]      voice_index,
  output logic            stolen,
  output logic [6:0]      start_note,
  output logic [6:0]      start_velocity,
  output logic            glide_valid,
  output logic [6:0]      glide_from_note,
  output logic [15:0]     released_mask
);

  localparam int IDXW = $clog2(NUM_VOICES);
  localparam int IXW  = (IDXW > 4) ? IDXW : 4;
  localparam int MW   = (NUM_VOICES > 16) ? NUM_VOICES : 16;

  logic [NUM_VOICES-1:0] active;
  logic [NUM_VOICES-1:0] releasing;
  logic [AGE_BITS-1:0]   age_mem [NUM_VOICES];
  logic [6:0]            note_mem [NUM_VOICES];
  logic [AGE_BITS-1:0]   age_rd;
  logic [6:0]            note_rd;

  logic [1:0]            cmd_reg;
  logic [6:0]            note_reg;
  logic [6:0]            vel_reg;
  logic [3:0]            sel_reg;
  logic [6:0]            last_note;
  logic                  last_valid;

  logic [IDXW-1:0]       cnt;
  logic                  s1_valid;
  logic [IDXW-1:0]       s1_idx;

  logic                  free_found;
  logic [IDXW-1:0]       free_idx;
  logic                  best_found;
  logic [IDXW-1:0]       best_idx;
  logic [AGE_BITS-1:0]   best_age;
  logic [15:0]           scan_mask;

  logic                  is_on;
  logic                  is_off;
  logic                  is_all;
  logic                  is_done;
  logic [AGE_BITS-1:0]   aged;
  logic                  s1_active;
  logic [IDXW-1:0]       pick;
  logic [IXW-1:0]        pick_wide;
  logic [IXW-1:0]        sel_wide;
  logic [IDXW-1:0]       sel_idx;
  logic                  sel_ok;
  logic [MW-1:0]         all_wide;
  logic [15:0]           all_mask;

  assign is_on   = (cmd_reg == pva_pkg::CMD_NOTE_ON);
  assign is_off  = (cmd_reg == pva_pkg::CMD_NOTE_OFF);
  assign is_all  = (cmd_reg == pva_pkg::CMD_ALL_OFF);
  assign is_done = (cmd_reg == pva_pkg::CMD_VOICE_DONE);

  assign stat.in_scan   = (command == pva_pkg::CMD_NOTE_ON) ||
                          (command == pva_pkg::CMD_NOTE_OFF);
  assign stat.scan_last = (cnt == IDXW'(NUM_VOICES - 1));

  assign s1_active = active[s1_idx];
  assign aged      = (age_rd == {AGE_BITS{1'b1}}) ? age_rd : age_rd + 1'b1;

  // With no idle voice left, the oldest one is stolen.
  assign pick      = free_found ? free_idx : best_idx;
  assign pick_wide = IXW'(pick);

  assign sel_wide = IXW'(sel_reg);
  assign sel_idx  = sel_wide[IDXW-1:0];
  assign sel_ok   = (32'(sel_reg) < 32'(NUM_VOICES));

  assign all_wide = MW'(active & ~releasing);
  assign all_mask = all_wide[15:0];

  // Registered reads, one voice per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.scan_en) begin
      age_rd  <= age_mem[cnt];
      note_rd <= note_mem[cnt];
    end
  end

  // Ages are only meaningful for active voices, so no reset pass is needed.
  always_ff @(posedge clk) begin
    if (s1_valid && is_on && s1_active) begin
      age_mem[s1_idx] <= aged;
    end else if (ctrl.finish && is_on) begin
      age_mem[pick] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish && is_on) begin
      note_mem[pick] <= note_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_reg  <= command;
      note_reg <= note;
      vel_reg  <= velocity;
      sel_reg  <= voice_select;
    end
    if (ctrl.capture) begin
      cnt <= '0;
    end else if (ctrl.scan_en && !stat.scan_last) begin
      cnt <= cnt + 1'b1;
    end
    s1_idx <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      releasing  <= '0;
      last_valid <= 1'b0;
      s1_valid   <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
    end else begin
      s1_valid <= ctrl.scan_en;
      if (ctrl.capture) begin
        free_found <= 1'b0;
        best_found <= 1'b0;
        scan_mask  <= '0;
      end else if (s1_valid) begin
        if (is_on) begin
          if (!s1_active) begin
            if (!free_found) begin
              free_found <= 1'b1;
              free_idx   <= s1_idx;
            end
          end else if (!best_found || aged > best_age) begin
            best_found <= 1'b1;
            best_idx   <= s1_idx;
            best_age   <= aged;
          end
        end else if (s1_active && note_rd == note_reg) begin
          // Voices above fifteen shift out of the mask.
          if (!releasing[s1_idx]) begin
            scan_mask <= scan_mask | (16'd1 << s1_idx);
          end
          releasing[s1_idx] <= 1'b1;
        end
      end

      if (ctrl.finish) begin
        started         <= is_on;
        voice_index     <= is_on ? pick_wide[3:0] : 4'd0;
        stolen          <= is_on && !free_found;
        start_note      <= is_on ? note_reg : 7'd0;
        start_velocity  <= is_on ? vel_reg : 7'd0;
        glide_valid     <= is_on && last_valid;
        glide_from_note <= (is_on && last_valid) ? last_note : 7'd0;
        priority if (is_off) begin
          released_mask <= scan_mask;
        end else if (is_all) begin
          released_mask <= all_mask;
        end else begin
          released_mask <= '0;
        end

        if (is_on) begin
          active[pick]    <= 1'b1;
          releasing[pick] <= 1'b0;
          last_note       <= note_reg;
          last_valid      <= 1'b1;
        end else if (is_all) begin
          releasing <= releasing | active;
        end else if (is_done && sel_ok) begin
          active[sel_idx]    <= 1'b0;
          releasing[sel_idx] <= 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/polyphonic_voice_allocator.sv
// Polyphonic voice allocator with oldest-note stealing.
// Input channel (in_valid/in_ready) carries one note event per transaction:
// command, note, velocity and voice_select. Output channel (out_valid/
// out_ready) returns exactly one result transaction per input transaction.
// Note on and note off walk the voice table one voice per cycle through a
// single read port of the age and note memories before their result is
// loaded. All notes off and voice done need no walk and go straight to
// loading their result. One event is in flight at a time; in_ready returns
// as the result is loaded, and the next event is accepted while that result
// waits.
// If the receiver stalls, a finished event holds in the controller until the
// output register is free; nothing is dropped.
// Reset clears every voice's active and releasing flags and forgets the
// previous note. Voice ages and notes need no clearing pass because they
// are only read for voices that are active.
module polyphonic_voice_allocator #(
  parameter int NUM_VOICES = 16,
  parameter int AGE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [6:0]  note,
  input  logic [6:0]  velocity,
  input  logic [3:0]  voice_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        started,
  output logic [3:0]  voice_index,
  output logic        stolen,
  output logic [6:0]  start_note,
  output logic [6:0]  start_velocity,
  output logic        glide_valid,
  output logic [6:0]  glide_from_note,
  output logic [15:0] released_mask
);

  pva_pkg::ctrl_t ctrl;
  pva_pkg::stat_t stat;

  pva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  pva_datapath #(
    .NUM_VOICES (NUM_VOICES),
    .AGE_BITS   (AGE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .stat            (stat),
    .command         (command),
    .note            (note),
    .velocity        (velocity),
    .voice_select    (voice_select),
    .started         (started),
    .voice_index     (voice_index),
    .stolen          (stolen),
    .start_note      (start_note),
    .start_velocity  (start_velocity),
    .glide_valid     (glide_valid),
    .glide_from_note (glide_from_note),
    .released_mask   (released_mask)
  );

endmodule
